[hw/rtl/ogma_pkg.sv]
`default_nettype none
package ogma_pkg;

  // default build configuration
  localparam int CHANNELS_DEF  = 8;
  localparam int MAX_ORDER_DEF = 8;

  // fixed field widths
  localparam int CH_FIELD_W    = 3;
  localparam int SMP_W         = 16;
  localparam int SUM_W         = 24;
  localparam int CNT_W         = 8;
  localparam int ORDER_FIELD_W = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  // constants
  localparam logic [CNT_W-1:0]         CNT_SAT   = 8'hFF;
  localparam logic [SMP_W-1:0]         LIMIT_MAX = 16'hFFFF;
  localparam logic [ORDER_FIELD_W-1:0] ORDER_RST = 4'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_ORDER  = 1'b0,
    REG_OUTLIER_LIMIT = 1'b1
  } cfg_reg_t;

  // per-channel filter state, slot pointer kept apart since its width follows MAX_ORDER
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SMP_W-1:0] avg;
    logic [CNT_W-1:0] cnt;
    logic             full;
  } chan_state_t;

endpackage
`default_nettype wire

[hw/rtl/ogma_if.sv]
`default_nettype none
// sample channel
interface ogma_in_if import ogma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel;
  logic [SMP_W-1:0]      sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// average channel
interface ogma_out_if import ogma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// register write channel
interface ogma_cfg_if import ogma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/outlier_gated_moving_average.sv]
// Bank of per-channel boxcar moving averages over unsigned 16-bit samples with
// outlier gating. Each sample item names a channel; the block answers with one
// item holding that channel's average after the sample. A sample farther from the
// current average than the outlier limit register (0 = 65535) counts as abnormal
// and enters the window only once more than half a window of abnormal samples
// came in a row. Throughput is one item per clock unless the output stalls, also
// for back-to-back samples on the same channel; an accepted sample sits in the
// update stage registers as the history memory is read, then passes through the
// update stage into the output register that offers it. The sample history
// sits in a dual-read, single-write memory of CHANNELS << MAX_ORDER entries; a
// per-channel fill flag stands in for clearing it, so there is no clearing pass
// after reset or after a window_order write. Writing window_order restarts all
// channels; write registers only while no item is in flight.
`default_nettype none
module outlier_gated_moving_average import ogma_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ogma_in_if.sink    in_chan,
  ogma_out_if.source out_chan,
  ogma_cfg_if.sink   cfg_chan
);

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_DEPTH = CHANNELS << MAX_ORDER;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int ORD_W      = $clog2(MAX_ORDER + 1);
  localparam int ORD_RST_I  = (int'(ORDER_RST) > MAX_ORDER) ? MAX_ORDER : int'(ORDER_RST);
  localparam logic [ORD_W-1:0] ORD_RST  = ORD_W'(ORD_RST_I);
  localparam logic [ORD_W-1:0] ORD_MAX  = ORD_W'(MAX_ORDER);

  function automatic logic [ADDR_W-1:0] hist_addr(input logic [CH_IDX_W-1:0] idx,
                                                  input logic [MAX_ORDER-1:0] slot);
    hist_addr = (ADDR_W'(idx) << MAX_ORDER) | ADDR_W'(slot);
  endfunction

  // configuration registers
  logic [ORD_W-1:0] order_r;
  logic [SMP_W-1:0] limit_r;
  logic             cfg_wr;
  logic             restart;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr  = cfg_chan.valid && cfg_chan.ready;
  assign restart = cfg_wr && (cfg_reg_t'(cfg_chan.index) == REG_WINDOW_ORDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_RST;
      limit_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_WINDOW_ORDER: begin
          order_r <= (cfg_chan.data[ORDER_FIELD_W-1:0] > ORDER_FIELD_W'(MAX_ORDER)) ?
                     ORD_MAX : ORD_W'(cfg_chan.data[ORDER_FIELD_W-1:0]);
        end
        REG_OUTLIER_LIMIT: begin
          limit_r <= cfg_chan.data[SMP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // window-derived values
  logic [MAX_ORDER:0]   win_size;
  logic [CNT_W-1:0]     half_win;
  logic [MAX_ORDER-1:0] slot_mask;
  logic [SMP_W-1:0]     limit_eff;

  assign win_size  = {{MAX_ORDER{1'b0}}, 1'b1} << order_r;
  assign half_win  = CNT_W'(win_size >> 1);
  assign slot_mask = ~({MAX_ORDER{1'b1}} << order_r);
  assign limit_eff = (limit_r == '0) ? LIMIT_MAX : limit_r;

  // update stage registers
  logic                 e_valid_r;
  logic                 e_ok_r;
  logic [CH_IDX_W-1:0]  e_idx_r;
  logic [SMP_W-1:0]     e_smp_r;
  logic [MAX_ORDER-1:0] e_base_r;
  logic [MAX_ORDER-1:0] e_inc_r;
  logic                 e_sel_inc_r;
  logic                 e_byp_r;
  logic [ADDR_W-1:0]    e_byp_addr_r;
  logic [SMP_W-1:0]     e_byp_data_r;

  // output register
  logic             out_valid_r;
  logic [SMP_W-1:0] out_avg_r;

  logic advance;
  logic accept;

  assign advance      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !e_valid_r || advance;
  assign accept       = in_chan.valid && in_chan.ready;

  // channel state access
  chan_state_t          st;
  logic [MAX_ORDER-1:0] slot_a;
  chan_state_t          st_wr;
  logic [MAX_ORDER-1:0] slot_wr;
  logic                 st_we;

  logic [CH_IDX_W-1:0] in_idx;
  logic                in_ok;

  assign in_idx = CH_IDX_W'(in_chan.channel);
  assign in_ok  = (32'(in_chan.channel) < CHANNELS);

  ogma_chan_regs #(
    .CHANNELS  (CHANNELS),
    .MAX_ORDER (MAX_ORDER),
    .CH_IDX_W  (CH_IDX_W)
  ) u_chan_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .wr_en    (st_we),
    .wr_idx   (e_idx_r),
    .wr_state (st_wr),
    .wr_slot  (slot_wr),
    .st_idx   (e_idx_r),
    .st_rd    (st),
    .slot_idx (in_idx),
    .slot_rd  (slot_a)
  );

  // update stage: outlier test, count and window step
  logic [MAX_ORDER-1:0] e_slot;
  logic [ADDR_W-1:0]    e_addr;
  logic [SMP_W-1:0]     rd0;
  logic [SMP_W-1:0]     rd1;
  logic [SMP_W-1:0]     rd_sel;
  logic [SMP_W-1:0]     hist_old;
  logic [SMP_W-1:0]     dev;
  logic                 abnormal;
  logic [CNT_W-1:0]     cnt_new;
  logic                 take;
  logic                 wrap;
  logic [MAX_ORDER-1:0] slot_next;
  logic [SUM_W-1:0]     sum_new;
  logic [SMP_W-1:0]     avg_new;
  logic [SMP_W-1:0]     e_avg;

  assign e_slot   = e_sel_inc_r ? e_inc_r : e_base_r;
  assign e_addr   = hist_addr(e_idx_r, e_slot);
  assign rd_sel   = e_sel_inc_r ? rd1 : rd0;

  // unfilled slots read as zero; the write of the item just ahead is forwarded
  always_comb begin
    if (!st.full) begin
      hist_old = '0;
    end else if (e_byp_r && (e_byp_addr_r == e_addr)) begin
      hist_old = e_byp_data_r;
    end else begin
      hist_old = rd_sel;
    end
  end

  assign dev      = (e_smp_r >= st.avg) ? (e_smp_r - st.avg) : (st.avg - e_smp_r);
  assign abnormal = dev > limit_eff;
  assign cnt_new  = !abnormal ? '0 : ((st.cnt == CNT_SAT) ? CNT_SAT : st.cnt + 1'b1);
  assign take     = e_ok_r && (!abnormal || (cnt_new > half_win));

  assign wrap      = (e_slot == slot_mask);
  assign slot_next = wrap ? '0 : e_slot + 1'b1;
  assign sum_new   = st.sum + SUM_W'(e_smp_r) - SUM_W'(hist_old);
  assign avg_new   = SMP_W'(sum_new >> order_r);

  always_comb begin
    if (take) begin
      st_wr   = '{sum: sum_new, avg: avg_new, cnt: cnt_new, full: st.full || wrap};
      slot_wr = slot_next;
    end else begin
      st_wr   = '{sum: st.sum, avg: st.avg, cnt: cnt_new, full: st.full};
      slot_wr = e_slot;
    end
  end

  assign st_we = advance && e_valid_r && e_ok_r;
  assign e_avg = !e_ok_r ? '0 : (take ? avg_new : st.avg);

  // slot for the incoming item, following the item ahead on the same channel
  logic                 same_prev;
  logic [MAX_ORDER-1:0] base_a;
  logic [MAX_ORDER-1:0] inc_a;

  assign same_prev = e_valid_r && e_ok_r && in_ok && (e_idx_r == in_idx);
  assign base_a    = same_prev ? e_slot : slot_a;
  assign inc_a     = (base_a == slot_mask) ? '0 : base_a + 1'b1;

  // history memory: read both candidate slots, resolve in the update stage
  ogma_hist_ram #(
    .DEPTH  (HIST_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_hist_ram (
    .clk    (clk),
    .we     (advance && e_valid_r && take),
    .waddr  (e_addr),
    .wdata  (e_smp_r),
    .re     (accept),
    .raddr0 (hist_addr(in_idx, base_a)),
    .raddr1 (hist_addr(in_idx, inc_a)),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      e_valid_r <= in_chan.valid;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      e_ok_r       <= in_ok;
      e_idx_r      <= in_idx;
      e_smp_r      <= in_chan.sample;
      e_base_r     <= base_a;
      e_inc_r      <= inc_a;
      e_sel_inc_r  <= same_prev && take;
      e_byp_r      <= e_valid_r && take;
      e_byp_addr_r <= e_addr;
      e_byp_data_r <= e_smp_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && e_valid_r) begin
      out_avg_r <= e_avg;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.average = out_avg_r;

endmodule
`default_nettype wire

[hw/rtl/ogma_hist_ram.sv]
`default_nettype none
module ogma_hist_ram import ogma_pkg::*; #(
  parameter int DEPTH  = CHANNELS_DEF << MAX_ORDER_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [SMP_W-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr0,
  input  wire logic [ADDR_W-1:0] raddr1,
  output logic      [SMP_W-1:0]  rdata0,
  output logic      [SMP_W-1:0]  rdata1
);

  logic [SMP_W-1:0] mem_r [DEPTH];
  logic [SMP_W-1:0] rdata0_r;
  logic [SMP_W-1:0] rdata1_r;

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // two registered read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= mem_r[raddr0];
      rdata1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule
`default_nettype wire

[hw/rtl/ogma_chan_regs.sv]
`default_nettype none
module ogma_chan_regs import ogma_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 restart,
  input  wire logic                 wr_en,
  input  wire logic [CH_IDX_W-1:0]  wr_idx,
  input  wire chan_state_t          wr_state,
  input  wire logic [MAX_ORDER-1:0] wr_slot,
  input  wire logic [CH_IDX_W-1:0]  st_idx,
  output chan_state_t               st_rd,
  input  wire logic [CH_IDX_W-1:0]  slot_idx,
  output logic      [MAX_ORDER-1:0] slot_rd
);

  chan_state_t          state_r [CHANNELS];
  logic [MAX_ORDER-1:0] slot_r  [CHANNELS];

  // reset and window restart put every channel back to its start state
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int c = 0; c < CHANNELS; c++) begin
        state_r[c] <= '{sum: '0, avg: '0, cnt: CNT_SAT, full: 1'b0};
        slot_r[c]  <= '0;
      end
    end else if (wr_en) begin
      state_r[wr_idx] <= wr_state;
      slot_r[wr_idx]  <= wr_slot;
    end
  end

  assign st_rd   = state_r[st_idx];
  assign slot_rd = slot_r[slot_idx];

endmodule
`default_nettype wire

[hw/rtl/ogma_checker.sv]
`default_nettype none
module ogma_props import ogma_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [SMP_W-1:0] out_average
);

  logic [2:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_average))
    else $error("result item changed while stalled");

  // an empty output register never blocks the input
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // at most two items in flight, and no result without an item behind it
  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r <= 3'd2) && (!out_valid || (inflight_r != 3'd0)))
    else $error("item count out of step");

endmodule

bind outlier_gated_moving_average ogma_props u_ogma_props (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_average (out_chan.average)
);
`default_nettype wire

[bench/ogma_checker.sv]
`timescale 1ns / 100ps
module ogma_checker import ogma_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ogma_in_if   in_mon,
  ogma_out_if  out_mon,
  ogma_cfg_if  cfg_mon,
  output int   in_flight,
  output int   mismatches
);

  localparam int NCH   = CHANNELS_DEF;
  localparam int DEPTH = 1 << MAX_ORDER_DEF;

  // shadow copy of the configuration and per-channel filter state
  logic [ORDER_FIELD_W-1:0] win_order;
  logic [SMP_W-1:0]         dlimit;
  logic [SMP_W-1:0]         hist [NCH][DEPTH];
  logic [SUM_W-1:0]         sum_r [NCH];
  logic [SMP_W-1:0]         avg_r [NCH];
  logic [7:0]               slot_r [NCH];
  logic [CNT_W-1:0]         cnt_r [NCH];

  logic [SMP_W-1:0] avg_expect_q [$];
  logic [SMP_W-1:0] want;
  bit               in_fire;
  bit               out_fire;

  initial begin
    in_flight  = 0;
    mismatches = 0;
  end

  // every channel back to an empty window, counts saturated
  task automatic clear_channels();
    for (int c = 0; c < NCH; c++) begin
      for (int s = 0; s < DEPTH; s++) hist[c][s] = '0;
      sum_r[c]  = '0;
      avg_r[c]  = '0;
      slot_r[c] = '0;
      cnt_r[c]  = CNT_SAT;
    end
  endtask

  // one sample through the gated boxcar, returns the new channel average
  function automatic logic [SMP_W-1:0] filter_update(input logic [CH_FIELD_W-1:0] ch,
                                                     input logic [SMP_W-1:0] smp);
    int unsigned ord;
    int unsigned win;
    int unsigned lim;
    int unsigned dev;
    int unsigned slot;
    bit          abnormal;
    ord  = (win_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : win_order;
    win  = 1 << ord;
    lim  = (dlimit == '0) ? LIMIT_MAX : dlimit;
    dev  = (smp >= avg_r[ch]) ? smp - avg_r[ch] : avg_r[ch] - smp;
    abnormal = dev > lim;
    // saturating run length of outliers
    if (abnormal) begin
      if (cnt_r[ch] != CNT_SAT) cnt_r[ch] = cnt_r[ch] + 1'b1;
    end else begin
      cnt_r[ch] = '0;
    end
    // outliers only get in after more than half a window of them
    if (!abnormal || cnt_r[ch] > (win >> 1)) begin
      slot      = slot_r[ch];
      sum_r[ch] = sum_r[ch] + smp - hist[ch][slot];
      avg_r[ch] = SMP_W'(sum_r[ch] >> ord);
      hist[ch][slot] = smp;
      slot_r[ch] = (slot + 1 >= win) ? 8'd0 : 8'(slot + 1);
    end
    return avg_r[ch];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      win_order = ORDER_RST;
      dlimit    = '0;
      clear_channels();
      avg_expect_q.delete();
      in_flight  <= 0;
      mismatches <= 0;
    end else begin
      in_fire  = in_mon.valid && in_mon.ready;
      out_fire = out_mon.valid && out_mon.ready;
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_WINDOW_ORDER) begin
          win_order = cfg_mon.data[ORDER_FIELD_W-1:0];
          clear_channels();
        end else if (cfg_mon.index == REG_OUTLIER_LIMIT) begin
          dlimit = cfg_mon.data;
        end
      end
      // compare result item against oldest expectation
      if (out_fire) begin
        if (avg_expect_q.size() == 0) begin
          $error("average: item with none expected, actual %0d", out_mon.average);
          mismatches <= mismatches + 1;
        end else begin
          want = avg_expect_q.pop_front();
          if (out_mon.average !== want) begin
            $error("average mismatch: expected %0d, actual %0d", want, out_mon.average);
            mismatches <= mismatches + 1;
          end
        end
      end
      // predict for the accepted sample item
      if (in_fire) avg_expect_q.push_back(filter_update(in_mon.channel, in_mon.sample));
      in_flight <= avg_expect_q.size();
    end
  end

endmodule

[bench/tb_outlier_gated_moving_average.sv]
`timescale 1ns / 100ps
module tb_outlier_gated_moving_average;
  import ogma_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 200;

  // per phase: whether order is written, order data, delta limit data
  localparam bit          PH_WR_ORDER [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};
  localparam logic [15:0] PH_ORDER [PHASES] = '{16'h0000, 16'h0008, 16'hFFFF, 16'h0002,
                                                16'h0005, 16'h0000, 16'h0005, 16'h0001};
  localparam logic [15:0] PH_LIMIT [PHASES] = '{16'd3, 16'd200, 16'd0, 16'd1,
                                                16'hFFFF, 16'd40, 16'd700, 16'd9};

  logic clk;
  logic rst_n;
  int   in_flight;
  int   mismatches;
  bit   idle_in;
  bit   idle_out;
  bit   hold_req;
  int   cur_limit;
  logic [SMP_W-1:0] level [CHANNELS_DEF];

  ogma_in_if  in_chan ();
  ogma_out_if out_chan ();
  ogma_cfg_if cfg_chan ();

  outlier_gated_moving_average dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ogma_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .in_flight  (in_flight),
    .mismatches (mismatches)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // offer one sample item, optional idle gap first
  task automatic send_sample(input logic [CH_FIELD_W-1:0] ch, input logic [SMP_W-1:0] smp);
    int gap;
    gap = idle_in ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.channel <= ch;
    in_chan.sample  <= smp;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // stop offering and wait for every average to come back
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  // register writes back to back, window order first when asked
  task automatic write_regs(input bit with_order, input logic [15:0] order_data,
                            input logic [15:0] limit_data);
    for (int k = with_order ? 0 : 1; k < 2; k++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= (k == 0) ? REG_WINDOW_ORDER : REG_OUTLIER_LIMIT;
      cfg_chan.data  <= (k == 0) ? order_data : limit_data;
      do @(posedge clk); while (!cfg_chan.ready);
    end
    cfg_chan.valid <= 1'b0;
    cur_limit = (limit_data == '0) ? 65535 : limit_data;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_out ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin : stimulus
    logic [CH_FIELD_W-1:0] ch;
    logic [SMP_W-1:0]      smp;
    int                    r;
    int                    span;
    int                    v;
    in_chan.valid   <= 1'b0;
    in_chan.channel <= '0;
    in_chan.sample  <= '0;
    cfg_chan.valid  <= 1'b0;
    cfg_chan.index  <= REG_WINDOW_ORDER;
    cfg_chan.data   <= '0;
    rst_n           <= 1'b0;
    idle_in   = 1'b1;
    idle_out  = 1'b1;
    hold_req  = 1'b0;
    cur_limit = 65535;
    ch        = '0;
    for (int c = 0; c < CHANNELS_DEF; c++) level[c] = 16'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: limit 0 so nothing is abnormal, field extremes
    send_sample(3'd0, 16'h0000);
    send_sample(3'd0, 16'hFFFF);
    send_sample(3'd7, 16'hFFFF);
    send_sample(3'd7, 16'hFFFF);
    send_sample(3'd1, 16'h5555);
    send_sample(3'd2, 16'hAAAA);
    send_sample(3'd3, 16'h0001);
    send_sample(3'd4, 16'h8000);
    send_sample(3'd5, 16'h7FFF);
    send_sample(3'd6, 16'd12345);
    wait_drained();

    // limit change keeps state; outlier run longer than half the window
    write_regs(1'b0, '0, 16'd16);
    send_sample(3'd0, 16'hFFFF);
    repeat (6) send_sample(3'd7, 16'h0000);
    send_sample(3'd7, 16'h0001);
    wait_drained();

    // random phases over several settings
    for (int p = 0; p < PHASES; p++) begin
      write_regs(PH_WR_ORDER[p], PH_ORDER[p], PH_LIMIT[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) {idle_in, idle_out} = 2'($urandom);
        if ((p == 1 || p == 4) && i == 40) hold_req = 1'b1;
        // sticky channel gives back-to-back samples on one channel
        if ($urandom_range(0, 1) == 0) ch = CH_FIELD_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          smp = 16'($urandom);
        end else begin
          // level step starts an outlier run
          if (r < 15) begin
            case ($urandom_range(0, 2))
              0:       level[ch] = 16'h0000;
              1:       level[ch] = 16'hFFFF;
              default: level[ch] = 16'($urandom);
            endcase
          end
          span = cur_limit / 2;
          v = level[ch];
          v = v + int'($urandom_range(0, 2 * span)) - span;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          smp = 16'(v);
        end
        send_sample(ch, smp);
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
